FILE: hw/rtl/lmfb_pkg.sv
// Shared types and constants for the LED matrix frame buffer block.
// No dependencies; imported by every module of the block.
package lmfb_pkg;

   localparam int NUM_ROWS    = 8;
   localparam int QUEUE_DEPTH = 2;

   // operation codes
   localparam logic [3:0] FUNC_PIXEL    = 4'd0;
   localparam logic [3:0] FUNC_ROW      = 4'd1;
   localparam logic [3:0] FUNC_COL      = 4'd2;
   localparam logic [3:0] FUNC_LOAD     = 4'd3;
   localparam logic [3:0] FUNC_SHL      = 4'd4;
   localparam logic [3:0] FUNC_SHR      = 4'd5;
   localparam logic [3:0] FUNC_ROTL     = 4'd6;
   localparam logic [3:0] FUNC_ROTR     = 4'd7;
   localparam logic [3:0] FUNC_INVERT   = 4'd8;
   localparam logic [3:0] FUNC_ROT90L   = 4'd9;
   localparam logic [3:0] FUNC_ROT90R   = 4'd10;
   localparam logic [3:0] FUNC_FLIP     = 4'd11;
   localparam logic [3:0] FUNC_REVERSE  = 4'd12;
   localparam logic [3:0] FUNC_CLEAR    = 4'd13;
   localparam logic [3:0] FUNC_UPDATE   = 4'd14;
   localparam logic [3:0] FUNC_UNUSED   = 4'd15;

   typedef struct packed {
      logic [3:0]  func;
      logic [2:0]  row_index;
      logic [2:0]  col_index;
      logic        pixel_on;
      logic [63:0] operand_word;
   } req_type;

   typedef struct packed {
      logic [3:0] register_address;
      logic [7:0] row_data;
      logic       last_row;
   } rsp_type;

   // decoded operation handed from front end to back end
   typedef struct packed {
      req_type op;
      logic    emit;
   } cmd_type;

endpackage

FILE: hw/rtl/led_matrix_frame_buffer_ops_top.sv
// LED matrix 8x8 frame buffer: front end, command queue, back end.
// Path: the request word is written into the command queue; the back end pops
// it, updates the frame and streams its rows, one row word per cycle from the
// row counter while rsp_stall is low. A word that emits no rows streams none.
// Reset: frame cleared to zero, auto_update set to 1, queue emptied.
module led_matrix_frame_buffer_ops_top #(
   parameter int QueueDepth = lmfb_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lmfb_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lmfb_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_wdata
);
   import lmfb_pkg::*;

   logic    auto_update_ff, auto_update_in;
   logic    push, pop, q_full, q_empty;
   cmd_type push_cmd, q_cmd;

   assign csr_ready      = 1'b1;
   assign auto_update_in = (csr_valid && csr_ready) ? csr_wdata : auto_update_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_update_ff <= 1'b1;
      end else begin
         auto_update_ff <= auto_update_in;
      end
   end

   lmfb_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .auto_update (auto_update_ff),
      .q_full      (q_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   lmfb_queue #(
      .DEPTH (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (q_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   lmfb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_cmd       (q_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // a run of eight rows is never cut short
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_payload.last_row |=> rsp_valid)
      else $error("row run broken before last row");

   // rows of a run go out in address order
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_payload.last_row
      |=> rsp_payload.register_address == $past(rsp_payload.register_address) + 4'd1)
      else $error("row address out of sequence");

   // the last flag comes with the eighth address only
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.last_row == (rsp_payload.register_address == 4'd8)))
      else $error("last_row mismatch");

   // first cycle out of reset carries no row word
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("row word out of reset");

endmodule

FILE: hw/rtl/lmfb_front.sv
// Front end: accepts request words, drops unused codes, tags row emission.
// Depends on lmfb_pkg.
module lmfb_front (
   input  logic             req_valid,
   output logic             req_stall,
   input  lmfb_pkg::req_type req_payload,
   input  logic             auto_update,
   input  logic             q_full,
   output logic             push,
   output lmfb_pkg::cmd_type push_cmd
);
   import lmfb_pkg::*;

   logic known_op;

   assign req_stall = q_full;
   assign known_op  = (req_payload.func != FUNC_UNUSED);

   // unused code is taken and dropped: no frame change, no rows
   assign push         = req_valid && !q_full && known_op;
   assign push_cmd.op  = req_payload;
   assign push_cmd.emit = (req_payload.func == FUNC_UPDATE) || auto_update;

endmodule

FILE: hw/rtl/lmfb_queue.sv
// Short command queue between front end and back end.
// Depends on lmfb_pkg for the command type.
module lmfb_queue #(
   parameter int DEPTH = lmfb_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lmfb_pkg::cmd_type push_cmd,
   input  logic             pop,
   output lmfb_pkg::cmd_type pop_cmd,
   output logic             full,
   output logic             empty
);
   import lmfb_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   cmd_type         mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full    = (count_ff == CntW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: hw/rtl/lmfb_back.sv
// Back end: holds the 8x8 frame, applies one operation, then streams rows if tagged.
// Depends on lmfb_pkg.
module lmfb_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  lmfb_pkg::cmd_type q_cmd,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lmfb_pkg::rsp_type rsp_payload
);
   import lmfb_pkg::*;

   logic [7:0] frame_ff [NUM_ROWS];
   logic [7:0] frame_in [NUM_ROWS];
   logic       emit_ff, emit_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       rsp_accept;
   logic       last;
   logic [7:0] colbit;
   logic [7:0] data;

   assign last       = (cnt_ff == 3'd7);
   assign rsp_accept = emit_ff && !rsp_stall;
   // next word may be taken in the same cycle the final row leaves
   assign pop        = !q_empty && (!emit_ff || (rsp_accept && last));

   assign rsp_valid                    = emit_ff;
   assign rsp_payload.register_address = {1'b0, cnt_ff} + 4'd1;
   assign rsp_payload.row_data         = frame_ff[cnt_ff];
   assign rsp_payload.last_row         = last;

   assign colbit = 8'h80 >> q_cmd.op.col_index;
   assign data   = q_cmd.op.operand_word[7:0];

   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         frame_in[r] = frame_ff[r];
      end
      if (pop) begin
         unique case (q_cmd.op.func)
            FUNC_PIXEL: begin
               if (q_cmd.op.pixel_on) begin
                  frame_in[q_cmd.op.row_index] = frame_ff[q_cmd.op.row_index] | colbit;
               end else begin
                  frame_in[q_cmd.op.row_index] = frame_ff[q_cmd.op.row_index] & ~colbit;
               end
            end
            FUNC_ROW: frame_in[q_cmd.op.row_index] = data;
            FUNC_COL: begin
               for (int r = 0; r < NUM_ROWS; r++) begin
                  frame_in[r] = data[7-r] ? (frame_ff[r] | colbit) : (frame_ff[r] & ~colbit);
               end
            end
            FUNC_LOAD: begin
               for (int r = 0; r < NUM_ROWS; r++) begin
                  frame_in[r] = q_cmd.op.operand_word[8*(7-r) +: 8];
               end
            end
            FUNC_SHL: begin
               for (int r = 0; r < NUM_ROWS; r++) frame_in[r] = {frame_ff[r][6:0], 1'b0};
            end
            FUNC_SHR: begin
               for (int r = 0; r < NUM_ROWS; r++) frame_in[r] = {1'b0, frame_ff[r][7:1]};
            end
            FUNC_ROTL: begin
               for (int r = 0; r < NUM_ROWS; r++) begin
                  frame_in[r] = {frame_ff[r][6:0], frame_ff[r][7]};
               end
            end
            FUNC_ROTR: begin
               for (int r = 0; r < NUM_ROWS; r++) begin
                  frame_in[r] = {frame_ff[r][0], frame_ff[r][7:1]};
               end
            end
            FUNC_INVERT: begin
               for (int r = 0; r < NUM_ROWS; r++) frame_in[r] = ~frame_ff[r];
            end
            FUNC_ROT90L: begin
               // new row r, bit 7-c takes old row c, bit r
               for (int r = 0; r < NUM_ROWS; r++) begin
                  for (int c = 0; c < NUM_ROWS; c++) begin
                     frame_in[r][7-c] = frame_ff[c][r];
                  end
               end
            end
            FUNC_ROT90R: begin
               // new row r, bit k takes old row k, bit 7-r
               for (int r = 0; r < NUM_ROWS; r++) begin
                  for (int k = 0; k < NUM_ROWS; k++) begin
                     frame_in[r][k] = frame_ff[k][7-r];
                  end
               end
            end
            FUNC_FLIP: begin
               for (int r = 0; r < NUM_ROWS; r++) frame_in[r] = frame_ff[7-r];
            end
            FUNC_REVERSE: begin
               for (int r = 0; r < NUM_ROWS; r++) begin
                  for (int k = 0; k < NUM_ROWS; k++) begin
                     frame_in[r][k] = frame_ff[r][7-k];
                  end
               end
            end
            FUNC_CLEAR: begin
               for (int r = 0; r < NUM_ROWS; r++) frame_in[r] = 8'h00;
            end
            default: ;  // update and unused code leave the frame alone
         endcase
      end
   end

   always_comb begin
      emit_in = emit_ff;
      cnt_in  = cnt_ff;
      if (rsp_accept) begin
         cnt_in = cnt_ff + 3'd1;
         if (last) begin
            emit_in = 1'b0;
         end
      end
      if (pop) begin
         emit_in = q_cmd.emit;
         cnt_in  = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff <= 1'b0;
         cnt_ff  <= 3'd0;
         for (int r = 0; r < NUM_ROWS; r++) frame_ff[r] <= 8'h00;
      end else begin
         emit_ff <= emit_in;
         cnt_ff  <= cnt_in;
         for (int r = 0; r < NUM_ROWS; r++) frame_ff[r] <= frame_in[r];
      end
   end

endmodule
